// ----- src/vector_distance_unit_core_assert.svh -----
// assertion macros for the vector distance unit
`ifndef VECTOR_DISTANCE_UNIT_CORE_ASSERT_SVH
`define VECTOR_DISTANCE_UNIT_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define VDU_CHECK(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("vdu check failed");
// next-cycle implication
`define VDU_CHECK_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("vdu next-cycle check failed");
`else
`define VDU_CHECK(lbl, clk_i, rst_ni, ante, cons)
`define VDU_CHECK_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

// ----- src/vdu_pkg.sv -----
// shared constants for the vector distance unit
`default_nettype none
package vdu_pkg;

	localparam int MAX_LENGTH_DEF  = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ELEM_W   = 16;
	localparam int METRIC_W = 3;
	localparam int SUM_W    = 48;
	localparam int DIST_W   = 48;
	localparam int AD_W     = 16;
	localparam int ROOT_W   = 32;
	localparam int RAD_W    = 64;

	localparam int DIV_STEPS  = RAD_W;
	localparam int SQRT_STEPS = RAD_W / 2;

	localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 3'd0;
	localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 3'd1;
	localparam logic [METRIC_W-1:0] METRIC_RMS       = 3'd2;
	localparam logic [METRIC_W-1:0] METRIC_SQUARED   = 3'd3;
	localparam logic [METRIC_W-1:0] METRIC_CHEBYSHEV = 3'd4;
	localparam logic [METRIC_W-1:0] METRIC_RESET     = METRIC_EUCLID;

endpackage
`default_nettype wire

// ----- src/vector_distance_unit_core.sv -----
// top level of the vector distance unit
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   metric
//  in       in         in_valid/in_stall     a_value, b_value, last_element
//  out      out        out_valid/out_stall   distance, element_count
//
// one element pair is taken every cycle unless in_stall is high; it is accumulated in the
// cycle after acceptance; finished vectors wait in a four-entry job queue; the back end
// goes straight to done for manhattan, squared and chebyshev, via a 32-step root for
// euclidean, via a 64-step divider then the root for rms; done loads the output register
// in_stall rises only while the job queue is nearly full; out_stall holds a waiting result
// arst_n clears the accumulators, the queue and out_valid; metric resets to euclidean
`default_nettype none
module vector_distance_unit_core #(
	parameter int MAX_LENGTH  = vdu_pkg::MAX_LENGTH_DEF,
	parameter int QUEUE_DEPTH = vdu_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(MAX_LENGTH + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vdu_pkg::METRIC_W-1:0]        metric,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   a_value,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   b_value,
	input  wire logic                                last_element,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [vdu_pkg::DIST_W-1:0]               distance,
	output logic [CNT_W-1:0]                         element_count
);
	import vdu_pkg::*;

	localparam int JOB_W = METRIC_W + SUM_W + AD_W + CNT_W;

	logic             q_push;
	logic [JOB_W-1:0] q_wdata;
	logic             q_pop;
	logic [JOB_W-1:0] q_rdata;
	logic             q_empty;
	logic             q_afull;

	vdu_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.metric       (metric),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.a_value      (a_value),
		.b_value      (b_value),
		.last_element (last_element),
		.q_afull      (q_afull),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	vdu_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.afull  (q_afull)
	);

	vdu_back #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_rdata       (q_rdata),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.distance      (distance),
		.element_count (element_count)
	);

endmodule
`default_nettype wire

// ----- src/vdu_front.sv -----
// front end: metric register, difference stage and accumulators
`default_nettype none
module vdu_front #(
	parameter int MAX_LENGTH = vdu_pkg::MAX_LENGTH_DEF,
	localparam int CNT_W = $clog2(MAX_LENGTH + 1),
	localparam int JOB_W = vdu_pkg::METRIC_W + vdu_pkg::SUM_W + vdu_pkg::AD_W + CNT_W
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vdu_pkg::METRIC_W-1:0]        metric,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   a_value,
	input  wire logic signed [vdu_pkg::ELEM_W-1:0]   b_value,
	input  wire logic                                last_element,
	input  wire logic                                q_afull,
	output logic                                     q_push,
	output logic [JOB_W-1:0]                         q_wdata
);
	import vdu_pkg::*;

	logic [METRIC_W-1:0]     metric_q;
	logic                    valid_s1;
	logic                    last_s1;
	logic [METRIC_W-1:0]     metric_s1;
	logic [AD_W-1:0]         ad_s1;
	logic [SUM_W-1:0]        sum_q;
	logic [AD_W-1:0]         max_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [ELEM_W:0]  diff;
	logic [ELEM_W:0]         diff_abs;
	logic                    accept;
	logic [2*AD_W-1:0]       square;
	logic [2*AD_W-1:0]       addend;
	logic [SUM_W:0]          sum_wide;
	logic [SUM_W-1:0]        sum_nx;
	logic [AD_W-1:0]         max_nx;
	logic [CNT_W-1:0]        cnt_nx;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_afull;
	assign accept    = in_valid && !in_stall;

	assign diff     = {a_value[ELEM_W-1], a_value} - {b_value[ELEM_W-1], b_value};
	assign diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;

	assign square   = ad_s1 * ad_s1;
	assign addend   = (metric_s1 == METRIC_MANHATTAN) ?
		{{(AD_W-8){1'b0}}, ad_s1, 8'b0} : square;
	assign sum_wide = {1'b0, sum_q} + {{(SUM_W+1-2*AD_W){1'b0}}, addend};
	assign sum_nx   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
	assign max_nx   = (ad_s1 > max_q) ? ad_s1 : max_q;
	assign cnt_nx   = (cnt_q < CNT_W'(MAX_LENGTH)) ? cnt_q + 1'b1 : cnt_q;

	assign q_push  = valid_s1 && last_s1;
	assign q_wdata = {metric_s1, sum_nx, max_nx, cnt_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			metric_q <= metric;
		end
	end

	// stage 1: absolute difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ad_s1     <= diff_abs[AD_W-1:0];
			last_s1   <= last_element;
			metric_s1 <= metric_q;
		end
	end

	// stage 2: accumulate, clear after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				max_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				max_q <= max_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/vdu_queue.sv -----
// short job queue between front and back
`default_nettype none
module vdu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vdu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output logic                  afull
);
	import vdu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_pop;

	assign empty  = (level_q == '0);
	// one slot kept for the beat still in the difference stage
	assign afull  = (level_q >= LVL_W'(DEPTH - 1));
	assign rdata  = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

`include "vector_distance_unit_core_assert.svh"
	`VDU_CHECK(a_no_overflow, clk, arst_n, push && !do_pop, level_q != LVL_W'(DEPTH))
	`VDU_CHECK(a_level_bound, clk, arst_n, 1'b1, level_q <= LVL_W'(DEPTH))
	`VDU_CHECK(a_empty_ptrs, clk, arst_n, empty, wr_ptr_q == rd_ptr_q)

endmodule
`default_nettype wire

// ----- src/vdu_back.sv -----
// back end: metric selection, serial divider and serial square root
`default_nettype none
module vdu_back #(
	parameter int MAX_LENGTH = vdu_pkg::MAX_LENGTH_DEF,
	localparam int CNT_W = $clog2(MAX_LENGTH + 1),
	localparam int JOB_W = vdu_pkg::METRIC_W + vdu_pkg::SUM_W + vdu_pkg::AD_W + CNT_W
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [JOB_W-1:0]             q_rdata,
	input  wire logic                         q_empty,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [vdu_pkg::DIST_W-1:0]        distance,
	output logic [CNT_W-1:0]                  element_count
);
	import vdu_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int SREM_W = ROOT_W + 4;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_DONE} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [METRIC_W-1:0] metric_q;
	logic [CNT_W-1:0]    n_q;
	logic [RAD_W-1:0]    x_q;
	logic [CNT_W-1:0]    drem_q;
	logic [SREM_W-1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [DIST_W-1:0]   res_q;
	logic                out_valid_q;
	logic [DIST_W-1:0]   distance_q;
	logic [CNT_W-1:0]    count_q;

	logic [METRIC_W-1:0] job_metric;
	logic [SUM_W-1:0]    job_sum;
	logic [AD_W-1:0]     job_max;
	logic [CNT_W-1:0]    job_cnt;
	logic [CNT_W:0]      dshift;
	logic                dbit;
	logic [SREM_W-1:0]   sshift;
	logic [SREM_W-1:0]   strial;
	logic                sbit;
	logic [ROOT_W-1:0]   root_nx;
	logic                load_out;

	assign {job_metric, job_sum, job_max, job_cnt} = q_rdata;

	// restoring division, one quotient bit per cycle
	assign dshift = {drem_q, x_q[RAD_W-1]};
	assign dbit   = (dshift >= {1'b0, n_q});

	// digit-by-digit square root, two radicand bits per cycle
	assign sshift  = {srem_q[SREM_W-3:0], x_q[RAD_W-1:RAD_W-2]};
	assign strial  = {{(SREM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
	assign sbit    = (sshift >= strial);
	assign root_nx = {root_q[ROOT_W-2:0], sbit};

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign out_valid     = out_valid_q;
	assign distance      = distance_q;
	assign element_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						metric_q <= job_metric;
						n_q      <= job_cnt;
						step_q   <= '0;
						drem_q   <= '0;
						srem_q   <= '0;
						root_q   <= '0;
						x_q      <= {job_sum, 16'b0};
						unique case (job_metric) inside
							METRIC_MANHATTAN, METRIC_SQUARED: begin
								res_q   <= job_sum;
								state_q <= ST_DONE;
							end
							METRIC_CHEBYSHEV: begin
								res_q   <= {{(DIST_W-AD_W-8){1'b0}}, job_max, 8'b0};
								state_q <= ST_DONE;
							end
							METRIC_EUCLID: begin
								state_q <= ST_SQRT;
							end
							METRIC_RMS: begin
								state_q <= ST_DIV;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DIV: begin
					drem_q <= dbit ? CNT_W'(dshift - {1'b0, n_q}) : dshift[CNT_W-1:0];
					x_q    <= {x_q[RAD_W-2:0], dbit};
					// the step count wraps to zero for the root
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					srem_q <= sbit ? (sshift - strial) : sshift;
					root_q <= root_nx;
					x_q    <= {x_q[RAD_W-3:0], 2'b00};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
						res_q   <= {{(DIST_W-ROOT_W){1'b0}}, root_nx};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						distance_q  <= res_q;
						count_q     <= n_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "vector_distance_unit_core_assert.svh"
	`VDU_CHECK(a_div_only_rms, clk, arst_n, state_q == ST_DIV, metric_q == METRIC_RMS)
	`VDU_CHECK(a_div_nonzero, clk, arst_n, state_q == ST_DIV, n_q != '0)
	`VDU_CHECK(a_sqrt_metric, clk, arst_n, state_q == ST_SQRT, metric_q == METRIC_RMS || metric_q == METRIC_EUCLID)
	`VDU_CHECK_NEXT(a_load_shows, clk, arst_n, load_out, out_valid && state_q == ST_IDLE)

endmodule
`default_nettype wire

// ----- tb/tb_vector_distance_unit_core.sv -----
// self-checking testbench for the vector distance unit core
`timescale 1ns / 1ps
module tb_vector_distance_unit_core;
	import vdu_pkg::*;

	localparam int CNT_W = $clog2(MAX_LENGTH_DEF + 1);
	localparam logic [63:0] SUM_LIMIT = 64'hFFFF_FFFF_FFFF;
	localparam logic [ELEM_W-1:0] ELEM_MAX = 16'h7FFF;
	localparam logic [ELEM_W-1:0] ELEM_MIN = 16'h8000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 120;
	localparam int RANDOM_PAIRS = 1200;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [CNT_W-1:0] count;
	} distance_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [METRIC_W-1:0] metric_data = METRIC_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [ELEM_W-1:0] a_value = '0;
	logic signed [ELEM_W-1:0] b_value = '0;
	logic last_element = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DIST_W-1:0] distance;
	logic [CNT_W-1:0] element_count;

	// running copy of the block's state
	logic [METRIC_W-1:0] metric_setting = METRIC_RESET;
	logic [63:0] run_sum = '0;
	logic [16:0] run_peak = '0;
	logic [CNT_W-1:0] run_pairs = '0;

	distance_result_t pending_results[$];
	distance_result_t want;
	int idle_pct = 26;
	int stall_pct = 26;
	int errors = 0;
	int checked = 0;
	int pairs_sent = 0;
	int results_by_metric[8] = '{default: 0};
	int cycle_count = 0;

	vector_distance_unit_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.metric(metric_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_value(a_value),
		.b_value(b_value),
		.last_element(last_element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.element_count(element_count)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if ({32'd0, trial} * {32'd0, trial} <= x) begin
				root = trial;
			end
		end
		return root;
	endfunction

	task automatic accumulate_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
			input logic last);
		logic signed [16:0] diff;
		logic [15:0] mag;
		logic [63:0] addend;
		logic [63:0] scaled;
		distance_result_t res;
		diff = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
		mag = diff[16] ? 16'(-diff) : diff[15:0];
		addend = (metric_setting == METRIC_MANHATTAN) ? {40'd0, mag, 8'd0} :
			64'(mag) * 64'(mag);
		if (run_sum > SUM_LIMIT - addend) begin
			run_sum = SUM_LIMIT;
		end else begin
			run_sum = run_sum + addend;
		end
		if (17'(mag) > run_peak) begin
			run_peak = 17'(mag);
		end
		if (run_pairs < MAX_LENGTH_DEF) begin
			run_pairs = run_pairs + 1'b1;
		end
		if (last) begin
			case (metric_setting)
				METRIC_MANHATTAN, METRIC_SQUARED: res.distance = run_sum[DIST_W-1:0];
				METRIC_EUCLID: res.distance = 48'(floor_sqrt(run_sum << 16));
				METRIC_RMS: begin
					scaled = (run_sum << 16) / 64'(run_pairs);
					res.distance = 48'(floor_sqrt(scaled));
				end
				METRIC_CHEBYSHEV: res.distance = 48'(run_peak) << 8;
				default: res.distance = '0;
			endcase
			res.count = run_pairs;
			pending_results.insert(pending_results.size(), res);
			results_by_metric[metric_setting]++;
			run_sum = '0;
			run_peak = '0;
			run_pairs = '0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			accumulate_pair(a_value, b_value, last_element);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: distance beat with none pending: distance %h count %0d",
					$time, distance, element_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (distance !== want.distance) begin
					$display("%0t: distance expected %h actual %h",
						$time, want.distance, distance);
					errors++;
				end
				if (element_count !== want.count) begin
					$display("%0t: element_count expected %0d actual %0d",
						$time, want.count, element_count);
					errors++;
				end
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("[vector_distance_unit_core] ERROR");
			$finish;
		end
	end

	function automatic logic [ELEM_W-1:0] random_element();
		case ($urandom_range(5))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return 16'($urandom_range(512)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [METRIC_W-1:0] random_metric();
		if ($urandom_range(9) == 0) begin
			return METRIC_W'($urandom_range(2 ** METRIC_W - 1, METRIC_CHEBYSHEV + 1));
		end
		return METRIC_W'($urandom_range(METRIC_CHEBYSHEV));
	endfunction

	task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
			input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			a_value <= 16'($urandom);
			b_value <= 16'($urandom);
			last_element <= 1'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_value <= a;
		b_value <= b;
		last_element <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		pairs_sent++;
	endtask

	task automatic pause_for_results(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_metric(input logic [METRIC_W-1:0] value);
		pause_for_results(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		metric_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		metric_setting = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_metric();
		send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
		send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
		send_pair('0, '0, 1'b1);
	endtask

	task automatic test_each_metric();
		for (int m = METRIC_MANHATTAN; m <= METRIC_CHEBYSHEV; m++) begin
			write_metric(METRIC_W'(m));
			send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
			send_pair(random_element(), random_element(), 1'b1);
		end
	endtask

	task automatic test_unused_metrics();
		for (int m = METRIC_CHEBYSHEV + 1; m < 2 ** METRIC_W; m++) begin
			write_metric(METRIC_W'(m));
			send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
		end
	endtask

	task automatic test_metric_switch_mid_vector();
		write_metric(METRIC_MANHATTAN);
		send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
		send_pair(16'h0180, 16'hFF00, 1'b0);
		write_metric(METRIC_SQUARED);
		send_pair(16'h0001, 16'h0000, 1'b1);
		send_pair(ELEM_MIN, 16'h0000, 1'b0);
		write_metric(METRIC_MANHATTAN);
		send_pair(16'h0100, ELEM_MAX, 1'b1);
	endtask

	task automatic test_random_vectors();
		int sent;
		int len;
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			idle_pct = (sent >= 400 && sent < 700) ? 0 : 26;
			stall_pct = idle_pct;
			if ($urandom_range(5) == 0) begin
				write_metric(random_metric());
			end else if ($urandom_range(14) == 0) begin
				pause_for_results(0);
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
			for (int i = 0; i < len; i++) begin
				if (len > 1 && i == len / 2 && $urandom_range(19) == 0) begin
					write_metric(random_metric());
				end
				send_pair(random_element(), random_element(), i == len - 1);
				sent++;
			end
		end
		idle_pct = 26;
		stall_pct = 26;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_metric();
		test_each_metric();
		test_unused_metrics();
		test_metric_switch_mid_vector();
		test_random_vectors();
		pause_for_results(END_CYCLES);
		$display("%0d element pairs sent, %0d distances checked", pairs_sent, checked);
		$display("by metric: manhattan %0d euclidean %0d rms %0d squared %0d chebyshev %0d unused %0d",
			results_by_metric[METRIC_MANHATTAN], results_by_metric[METRIC_EUCLID],
			results_by_metric[METRIC_RMS], results_by_metric[METRIC_SQUARED],
			results_by_metric[METRIC_CHEBYSHEV],
			results_by_metric[5] + results_by_metric[6] + results_by_metric[7]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[vector_distance_unit_core] OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending_results.size());
			$display("[vector_distance_unit_core] ERROR");
		end
		$finish;
	end

endmodule
